// File: rtl/pfde_pkg.sv
// Shared types and codes for the page frame buffer draw engine.
// No dependencies; used by the top level, front end, queue and back end.
`default_nettype none
package pfde_pkg;

  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_PIXEL = 3'd1;
  localparam logic [2:0] REQ_LINE  = 3'd2;
  localparam logic [2:0] REQ_SHIFT = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_PIXEL,
    OP_LINE,
    OP_SHIFT,
    OP_READ,
    OP_READ_ZERO
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] xs;
    logic [5:0] ys;
    logic [6:0] xe;
    logic [5:0] ye;
    logic       ink;
    logic [6:0] sh;
    logic [2:0] pg;
    logic [6:0] col;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LSTEP,
    ST_PRD,
    ST_PWR,
    ST_SRD,
    ST_SWR,
    ST_RD,
    ST_RWAIT,
    ST_RZERO
  } st_t;

endpackage
`default_nettype wire

// File: rtl/page_framebuffer_draw_engine.sv
// Top level of the page frame buffer draw engine: front end, command queue, back end.
// Depends on pfde_pkg, pfde_front, pfde_queue, pfde_back.
// The frame store is one RAM with one read and one write port, and every request runs
// through it one at a time. The back end takes a request from the queue in its idle state;
// a pixel then reads and writes its byte (read state, write state), a line steps, reads and
// writes once per plotted pixel (an off-screen pixel skips the read and the write), a shift
// reads and writes every byte of the store, and a clear or a shift of SCREEN_COLUMNS or more
// writes every byte once. A read fetches its byte and then waits for the result register.
// The pass after reset clears every byte of the store.
// in_tready stays low during every clear pass, including the one after reset; otherwise
// two requests can wait in the queue while the back end works.
`default_nettype none
module page_framebuffer_draw_engine #(
  parameter int SCREEN_COLUMNS = 84,
  parameter int SCREEN_PAGES   = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // req_type
  input  wire logic [2:0]                       in_tuser,
  // x_start, y_start, x_end, y_end, ink, shift_amount, read_page, read_column, zero pad
  input  wire logic [pfde_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // read_byte
  output logic [pfde_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  pfde_pkg::cmd_t    push_cmd, head;
  pfde_pkg::q_stat_t q_stat;
  logic              push, pop, init_busy;

  pfde_front #(.SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_PAGES(SCREEN_PAGES)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .init_busy (init_busy),
    .push      (push),
    .cmd       (push_cmd)
  );

  pfde_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  pfde_back #(.SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_PAGES(SCREEN_PAGES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule
`default_nettype wire

// File: rtl/pfde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/pfde_front.sv
// Front end: accepts request beats, decodes and classifies them into commands.
// Depends on pfde_pkg.
`default_nettype none
module pfde_front #(
  parameter int SCREEN_COLUMNS = 84,
  parameter int SCREEN_PAGES   = 6
) (
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [2:0]                      in_tuser,
  input  wire logic [pfde_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire pfde_pkg::q_stat_t               q_stat,
  input  wire logic                            init_busy,
  output logic                                 push,
  output pfde_pkg::cmd_t                       cmd
);
  logic keep;

  always_comb begin
    cmd.xs  = in_tdata[6:0];
    cmd.ys  = in_tdata[12:7];
    cmd.xe  = in_tdata[19:13];
    cmd.ye  = in_tdata[25:20];
    cmd.ink = in_tdata[26];
    cmd.sh  = in_tdata[33:27];
    cmd.pg  = in_tdata[36:34];
    cmd.col = in_tdata[43:37];
    cmd.op  = pfde_pkg::OP_CLEAR;
    keep    = 1'b1;
    case (in_tuser)
      pfde_pkg::REQ_CLEAR: cmd.op = pfde_pkg::OP_CLEAR;
      pfde_pkg::REQ_PIXEL: cmd.op = pfde_pkg::OP_PIXEL;
      pfde_pkg::REQ_LINE:  cmd.op = pfde_pkg::OP_LINE;
      pfde_pkg::REQ_SHIFT: begin
        if (cmd.sh == 7'd0) begin
          keep = 1'b0;
        end else if ({1'b0, cmd.sh} >= 8'(SCREEN_COLUMNS)) begin
          cmd.op = pfde_pkg::OP_CLEAR;
        end else begin
          cmd.op = pfde_pkg::OP_SHIFT;
        end
      end
      pfde_pkg::REQ_READ: begin
        if (({1'b0, cmd.pg} < 4'(SCREEN_PAGES)) &&
            ({1'b0, cmd.col} < 8'(SCREEN_COLUMNS))) begin
          cmd.op = pfde_pkg::OP_READ;
        end else begin
          cmd.op = pfde_pkg::OP_READ_ZERO;
        end
      end
      default: keep = 1'b0;
    endcase
    in_tready = !q_stat.full && !init_busy;
    push      = in_tvalid && in_tready && keep;
  end
endmodule
`default_nettype wire

// File: rtl/pfde_queue.sv
// Two-entry command queue between front end and back end.
// Depends on pfde_pkg.
`default_nettype none
module pfde_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pfde_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output pfde_pkg::cmd_t      head,
  output pfde_pkg::q_stat_t   stat
);
  pfde_pkg::cmd_t ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    head       = ent_r[rp_r];
    stat.full  = (cnt_r == 2'd2);
    stat.empty = (cnt_r == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

// File: rtl/pfde_back.sv
// Back end: executes commands on the frame store, owns the result register.
// Depends on pfde_pkg and pfde_ram.
`default_nettype none
module pfde_back #(
  parameter int SCREEN_COLUMNS = 84,
  parameter int SCREEN_PAGES   = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pfde_pkg::cmd_t         head,
  input  wire pfde_pkg::q_stat_t      q_stat,
  output logic                        pop,
  output logic                        init_busy,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [pfde_pkg::OUT_TDATA_W-1:0] out_tdata
);
  localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int ROWS  = SCREEN_PAGES * 8;
  localparam int AW    = $clog2(DEPTH);

  pfde_pkg::st_t st_r, st_nxt;
  logic          line_r, line_nxt, last_r, last_nxt, ov_r, ov_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [6:0]    px_r, px_nxt, cx_r, cx_nxt, xe_r, xe_nxt, col_r, col_nxt, sh_r, sh_nxt;
  logic [5:0]    py_r, py_nxt, cy_r, cy_nxt, ye_r, ye_nxt;
  logic [6:0]    maj_r, maj_nxt, min_r, min_nxt, cnt_r, cnt_nxt;
  logic [7:0]    rem_r, rem_nxt, od_r, od_nxt;
  logic          sx_r, sx_nxt, sy_r, sy_nxt, xmaj_r, xmaj_nxt, ink_r, ink_nxt, zf_r, zf_nxt;
  logic [2:0]    pg_r, pg_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  logic [6:0]    adx, ady;
  logic [7:0]    rsum, src;
  logic [7:0]    bitm;

  function automatic logic [AW-1:0] addr_of(input logic [2:0] p, input logic [6:0] c);
    return AW'(32'(p) * SCREEN_COLUMNS + 32'(c));
  endfunction

  pfde_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    st_nxt   = st_r;
    line_nxt = line_r;
    last_nxt = last_r;
    ov_nxt   = ov_r;
    clr_nxt  = clr_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    xe_nxt   = xe_r;
    ye_nxt   = ye_r;
    col_nxt  = col_r;
    sh_nxt   = sh_r;
    maj_nxt  = maj_r;
    min_nxt  = min_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    od_nxt   = od_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    xmaj_nxt = xmaj_r;
    ink_nxt  = ink_r;
    zf_nxt   = zf_r;
    pg_nxt   = pg_r;
    pop      = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = clr_r;
    raddr    = addr_of(pg_r, col_r);
    wdata    = 8'd0;
    adx      = (head.xe >= head.xs) ? head.xe - head.xs : head.xs - head.xe;
    ady      = 7'((head.ye >= head.ys) ? head.ye - head.ys : head.ys - head.ye);
    rsum     = rem_r + {1'b0, min_r};
    src      = {1'b0, col_r} + {1'b0, sh_r};
    bitm     = 8'(1) << py_r[2:0];
    if (out_tvalid && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      pfde_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        if (clr_r == AW'(DEPTH - 1)) begin
          clr_nxt = '0;
          st_nxt  = pfde_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      pfde_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          ink_nxt = head.ink;
          case (head.op)
            pfde_pkg::OP_CLEAR: st_nxt = pfde_pkg::ST_CLEAR;
            pfde_pkg::OP_PIXEL: begin
              line_nxt = 1'b0;
              px_nxt   = head.xs;
              py_nxt   = head.ys;
              st_nxt   = pfde_pkg::ST_PRD;
            end
            pfde_pkg::OP_LINE: begin
              line_nxt = 1'b1;
              last_nxt = 1'b0;
              cx_nxt   = head.xs;
              cy_nxt   = head.ys;
              xe_nxt   = head.xe;
              ye_nxt   = head.ye;
              sx_nxt   = head.xe < head.xs;
              sy_nxt   = head.ye < head.ys;
              xmaj_nxt = adx >= ady;
              maj_nxt  = (adx >= ady) ? adx : ady;
              min_nxt  = (adx >= ady) ? ady : adx;
              cnt_nxt  = (adx >= ady) ? adx : ady;
              rem_nxt  = 8'd0;
              st_nxt   = pfde_pkg::ST_LSTEP;
            end
            pfde_pkg::OP_SHIFT: begin
              sh_nxt  = head.sh;
              pg_nxt  = 3'd0;
              col_nxt = 7'd0;
              st_nxt  = pfde_pkg::ST_SRD;
            end
            pfde_pkg::OP_READ: begin
              pg_nxt  = head.pg;
              col_nxt = head.col;
              st_nxt  = pfde_pkg::ST_RD;
            end
            pfde_pkg::OP_READ_ZERO: st_nxt = pfde_pkg::ST_RZERO;
            default: st_nxt = pfde_pkg::ST_IDLE;
          endcase
        end
      end
      pfde_pkg::ST_LSTEP: begin
        st_nxt = pfde_pkg::ST_PRD;
        if (cnt_r == 7'd0) begin
          px_nxt   = xe_r;
          py_nxt   = ye_r;
          last_nxt = 1'b1;
        end else begin
          px_nxt  = cx_r;
          py_nxt  = cy_r;
          cnt_nxt = cnt_r - 7'd1;
          if (rsum >= {1'b0, maj_r}) begin
            rem_nxt = rsum - {1'b0, maj_r};
          end else begin
            rem_nxt = rsum;
          end
          if (xmaj_r) begin
            cx_nxt = sx_r ? cx_r - 7'd1 : cx_r + 7'd1;
            if (rsum >= {1'b0, maj_r}) begin
              cy_nxt = sy_r ? cy_r - 6'd1 : cy_r + 6'd1;
            end
          end else begin
            cy_nxt = sy_r ? cy_r - 6'd1 : cy_r + 6'd1;
            if (rsum >= {1'b0, maj_r}) begin
              cx_nxt = sx_r ? cx_r - 7'd1 : cx_r + 7'd1;
            end
          end
        end
      end
      pfde_pkg::ST_PRD: begin
        raddr = addr_of(py_r[5:3], px_r);
        if (({1'b0, px_r} >= 8'(SCREEN_COLUMNS)) || ({1'b0, py_r} >= 7'(ROWS))) begin
          st_nxt = (line_r && !last_r) ? pfde_pkg::ST_LSTEP : pfde_pkg::ST_IDLE;
        end else begin
          re     = 1'b1;
          st_nxt = pfde_pkg::ST_PWR;
        end
      end
      pfde_pkg::ST_PWR: begin
        we     = 1'b1;
        waddr  = addr_of(py_r[5:3], px_r);
        wdata  = ink_r ? (rdata | bitm) : (rdata & ~bitm);
        st_nxt = (line_r && !last_r) ? pfde_pkg::ST_LSTEP : pfde_pkg::ST_IDLE;
      end
      pfde_pkg::ST_SRD: begin
        raddr  = addr_of(pg_r, src[6:0]);
        zf_nxt = src >= 8'(SCREEN_COLUMNS);
        re     = src < 8'(SCREEN_COLUMNS);
        st_nxt = pfde_pkg::ST_SWR;
      end
      pfde_pkg::ST_SWR: begin
        we     = 1'b1;
        waddr  = addr_of(pg_r, col_r);
        wdata  = zf_r ? 8'd0 : rdata;
        st_nxt = pfde_pkg::ST_SRD;
        if (col_r == 7'(SCREEN_COLUMNS - 1)) begin
          col_nxt = 7'd0;
          pg_nxt  = pg_r + 3'd1;
          if (pg_r == 3'(SCREEN_PAGES - 1)) begin
            st_nxt = pfde_pkg::ST_IDLE;
          end
        end else begin
          col_nxt = col_r + 7'd1;
        end
      end
      pfde_pkg::ST_RD: begin
        re     = 1'b1;
        raddr  = addr_of(pg_r, col_r);
        st_nxt = pfde_pkg::ST_RWAIT;
      end
      pfde_pkg::ST_RWAIT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          od_nxt = rdata;
          st_nxt = pfde_pkg::ST_IDLE;
        end
      end
      pfde_pkg::ST_RZERO: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          od_nxt = 8'd0;
          st_nxt = pfde_pkg::ST_IDLE;
        end
      end
      default: st_nxt = pfde_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= pfde_pkg::ST_CLEAR;
      clr_r  <= '0;
      ov_r   <= 1'b0;
      line_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      ov_r   <= ov_nxt;
      line_r <= line_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    xe_r   <= xe_nxt;
    ye_r   <= ye_nxt;
    col_r  <= col_nxt;
    sh_r   <= sh_nxt;
    maj_r  <= maj_nxt;
    min_r  <= min_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    od_r   <= od_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    xmaj_r <= xmaj_nxt;
    ink_r  <= ink_nxt;
    zf_r   <= zf_nxt;
    pg_r   <= pg_nxt;
  end

  assign init_busy  = (st_r == pfde_pkg::ST_CLEAR);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule
`default_nettype wire

// File: rtl/pfde_checker.sv
// Port-level checker for the draw engine, bound to the top level.
// Depends on page_framebuffer_draw_engine.
`default_nettype none
module pfde_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("request beat taken during store clear");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped");
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result beat changed");
endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: test/tb_page_framebuffer_draw_engine.sv
// Testbench for page_framebuffer_draw_engine: drives draw, shift, clear, read and unused-type beats,
// predicts each read-back byte from a local copy of the frame store. Depends on pfde_pkg.
`timescale 1ns / 1ps
module tb_page_framebuffer_draw_engine;

  localparam int COLS = 84;
  localparam int PAGES = 6;
  localparam int ROWS = PAGES * 8;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [2:0] in_tuser;
  logic [pfde_pkg::IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [pfde_pkg::OUT_TDATA_W-1:0] out_tdata;

  logic [7:0] pixel_mem [COLS*PAGES];
  logic [7:0] byte_q [$];
  int errors;
  int send_gap_pct;
  int recv_gap_pct;
  int idle_cycles;

  page_framebuffer_draw_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic plot_px(int x, int y, bit ink);
    int idx;
    if (x < 0 || y < 0 || x >= COLS || y >= ROWS) return;
    idx = (y >> 3) * COLS + x;
    pixel_mem[idx][y & 7] = ink;
  endtask

  task automatic draw_line(int xa, int ya, int xb, int yb, bit ink);
    int dx, dy, sx, sy, adx, ady;
    dx = xb - xa;
    dy = yb - ya;
    sx = dx >= 0 ? 1 : -1;
    sy = dy >= 0 ? 1 : -1;
    adx = dx >= 0 ? dx : -dx;
    ady = dy >= 0 ? dy : -dy;
    if (adx >= ady) begin
      for (int i = 0; i < adx; i++) plot_px(xa + sx * i, ya + sy * ((ady * i) / adx), ink);
    end else begin
      for (int i = 0; i < ady; i++) plot_px(xa + sx * ((adx * i) / ady), ya + sy * i, ink);
    end
    plot_px(xb, yb, ink);
  endtask

  task automatic shift_frame(int n);
    if (n == 0) return;
    for (int p = 0; p < PAGES; p++)
      for (int c = 0; c < COLS; c++)
        pixel_mem[p*COLS + c] = (c + n < COLS) ? pixel_mem[p*COLS + c + n] : 8'h00;
  endtask

  task automatic apply_request(logic [2:0] req, logic [6:0] xs, logic [5:0] ys,
                               logic [6:0] xe, logic [5:0] ye, logic ink,
                               logic [6:0] sh, logic [2:0] pg, logic [6:0] col);
    case (req)
      pfde_pkg::REQ_CLEAR: foreach (pixel_mem[i]) pixel_mem[i] = 8'h00;
      pfde_pkg::REQ_PIXEL: plot_px(int'(xs), int'(ys), ink);
      pfde_pkg::REQ_LINE: draw_line(int'(xs), int'(ys), int'(xe), int'(ye), ink);
      pfde_pkg::REQ_SHIFT: shift_frame(int'(sh));
      pfde_pkg::REQ_READ: begin
        if (int'(pg) < PAGES && int'(col) < COLS)
          byte_q.push_back(pixel_mem[int'(pg)*COLS + int'(col)]);
        else byte_q.push_back(8'h00);
      end
      default: ;
    endcase
  endtask

  task automatic send_req(logic [2:0] req, int xs, int ys, int xe, int ye, int ink,
                          int sh, int pg, int col);
    logic [6:0] xs_v, xe_v, sh_v, col_v;
    logic [5:0] ys_v, ye_v;
    logic [2:0] pg_v;
    logic ink_v;
    xs_v = 7'(xs);
    ys_v = 6'(ys);
    xe_v = 7'(xe);
    ye_v = 6'(ye);
    ink_v = 1'(ink);
    sh_v = 7'(sh);
    pg_v = 3'(pg);
    col_v = 7'(col);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {4'b0, col_v, pg_v, sh_v, ink_v, ye_v, xe_v, ys_v, xs_v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(req, xs_v, ys_v, xe_v, ye_v, ink_v, sh_v, pg_v, col_v);
  endtask

  task automatic send_read(int pg, int col);
    send_req(pfde_pkg::REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             pg, col);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic read_some(int n);
    repeat (n) send_read($urandom_range(PAGES-1), $urandom_range(COLS-1));
  endtask

  task automatic test_directed();
    send_read(0, 0);
    send_req(pfde_pkg::REQ_PIXEL, 0, 0, 0, 0, 1, 0, 0, 0);
    send_req(pfde_pkg::REQ_PIXEL, 83, 47, 0, 0, 1, 0, 0, 0);
    send_req(pfde_pkg::REQ_PIXEL, 84, 5, 0, 0, 1, 0, 0, 0);
    send_req(pfde_pkg::REQ_PIXEL, 5, 48, 0, 0, 1, 0, 0, 0);
    send_req(pfde_pkg::REQ_PIXEL, 127, 63, 0, 0, 1, 0, 0, 0);
    send_read(0, 0);
    send_read(5, 83);
    send_req(pfde_pkg::REQ_LINE, 0, 0, 83, 47, 1, 0, 0, 0);
    send_req(pfde_pkg::REQ_LINE, 80, 40, 10, 2, 1, 0, 0, 0);
    send_req(pfde_pkg::REQ_LINE, 127, 63, 60, 10, 1, 0, 0, 0);
    send_req(pfde_pkg::REQ_LINE, 20, 20, 20, 20, 1, 0, 0, 0);
    send_req(pfde_pkg::REQ_LINE, 0, 0, 83, 47, 0, 0, 0, 0);
    send_read(2, 20);
    send_read(3, 40);
    send_req(pfde_pkg::REQ_SHIFT, 0, 0, 0, 0, 0, 0, 0, 0);
    send_read(5, 80);
    send_req(pfde_pkg::REQ_SHIFT, 0, 0, 0, 0, 0, 1, 0, 0);
    send_req(pfde_pkg::REQ_SHIFT, 0, 0, 0, 0, 0, 83, 0, 0);
    send_read(0, 0);
    send_req(pfde_pkg::REQ_LINE, 0, 47, 83, 0, 1, 0, 0, 0);
    send_req(pfde_pkg::REQ_SHIFT, 0, 0, 0, 0, 0, 127, 0, 0);
    send_read(6, 10);
    send_read(1, 84);
    send_read(7, 127);
    send_req(3'd5, 1, 1, 1, 1, 1, 1, 1, 1);
    send_req(3'd7, 1, 1, 1, 1, 1, 1, 1, 1);
    send_req(pfde_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, 1, 0, 0, 0);
    send_read(3, 3);
  endtask

  task automatic test_random(int n);
    int r;
    int xs, xe;
    int ys, ye;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      xs = $urandom_range(99) < 85 ? $urandom_range(COLS-1) : $urandom_range(127);
      ys = $urandom_range(99) < 85 ? $urandom_range(ROWS-1) : $urandom_range(63);
      if ($urandom_range(3) == 0) begin
        xe = $urandom_range(127);
        ye = $urandom_range(63);
      end else begin
        xe = $urandom_range(COLS-1);
        ye = $urandom_range(ROWS-1);
      end
      if (r < 30) send_req(pfde_pkg::REQ_PIXEL, xs, ys, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom);
      else if (r < 42) send_req(pfde_pkg::REQ_LINE, xs, ys, xe, ye, $urandom, $urandom,
                                $urandom, $urandom);
      else if (r < 44) send_req(pfde_pkg::REQ_SHIFT, $urandom, $urandom, $urandom, $urandom,
                                $urandom,
                                ($urandom_range(1) != 0) ? $urandom_range(8)
                                                         : $urandom_range(127),
                                $urandom, $urandom);
      else if (r < 45) send_req(pfde_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
      else if (r < 47) send_req(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (r < 95) send_read($urandom_range(PAGES-1), $urandom_range(COLS-1));
      else send_req(pfde_pkg::REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_gap_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (byte_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read_byte %h", out_tdata);
      end else begin
        if (out_tdata !== byte_q[0]) begin
          errors++;
          if (errors <= 10) $display("read_byte expected %h actual %h", byte_q[0], out_tdata);
        end
        void'(byte_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("page_framebuffer_draw_engine: mismatch");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    send_gap_pct = 27;
    recv_gap_pct = 82;
    foreach (pixel_mem[i]) pixel_mem[i] = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drain();
    test_random(480);
    read_some(20);
    wait_drain();
    send_gap_pct = 82;
    recv_gap_pct = 27;
    test_random(480);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random(440);
    wait_drain();
    if (errors == 0) $display("page_framebuffer_draw_engine: match");
    else $display("page_framebuffer_draw_engine: mismatch");
    $finish;
  end
endmodule
